// File: rtl/esr_pkg.sv
// Package for the encoder speed regulator: shared types, codes and constants.
// Used by esr_cfg_regs, esr_core and encoder_speed_regulator; depends on nothing.
package esr_pkg;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;

  // Half-width of the unsure band around the encoder middle.
  localparam logic [10:0] ClassMargin     = 11'd10;
  localparam logic [3:0]  AdjustHoldoff   = 4'd2;
  localparam logic [3:0]  InitialHoldoff  = 4'd8;

  localparam logic [9:0]  EncMiddleReset  = 10'd840;
  localparam logic [10:0] SlowIntvReset   = 11'd34;
  localparam logic [10:0] FastIntvReset   = 11'd22;
  localparam logic [9:0]  StallTicksReset = 10'd300;
  localparam logic [7:0]  StartStrReset   = 8'd80;
  localparam logic [7:0]  MaxStrReset     = 8'd100;
  localparam logic [7:0]  StartTurnReset  = 8'd120;
  localparam logic [7:0]  MaxTurnReset    = 8'd140;

  typedef enum logic [2:0] {
    REG_ENC_MIDDLE  = 3'd0,
    REG_SLOW_INTV   = 3'd1,
    REG_FAST_INTV   = 3'd2,
    REG_STALL_TICKS = 3'd3,
    REG_START_STR   = 3'd4,
    REG_MAX_STR     = 3'd5,
    REG_START_TURN  = 3'd6,
    REG_MAX_TURN    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ACT_STOP  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_BACK  = 3'd2,
    ACT_LEFT  = 3'd3,
    ACT_RIGHT = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    CL_UNSURE = 2'd0,
    CL_LOW    = 2'd1,
    CL_HIGH   = 2'd2
  } cls_e;

  typedef struct packed {
    logic [9:0]  encoder_middle;
    logic [10:0] slow_interval;
    logic [10:0] fast_interval;
    logic [9:0]  stall_ticks;
    logic [7:0]  start_speed_straight;
    logic [7:0]  max_speed_straight;
    logic [7:0]  start_speed_turn;
    logic [7:0]  max_speed_turn;
  } cfg_t;

  typedef struct packed {
    logic        motor_enable;
    logic        motor_reverse;
    logic [7:0]  drive_level;
    logic [15:0] sector_count;
    logic        sector_event;
    logic        stall_fault;
  } res_t;

endpackage

// File: rtl/esr_cfg_regs.sv
// Configuration register file of the encoder speed regulator behind an APB-style port.
// Depends on esr_pkg for the register map and the cfg_t bundle.
module esr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [esr_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [esr_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [esr_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                 pready,
  output esr_pkg::cfg_t                        cfg_o
);

  esr_pkg::cfg_t     cfg_q;
  esr_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = esr_pkg::reg_idx_e'(paddr[esr_pkg::CfgAddrWidth-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encoder_middle       <= esr_pkg::EncMiddleReset;
      cfg_q.slow_interval        <= esr_pkg::SlowIntvReset;
      cfg_q.fast_interval        <= esr_pkg::FastIntvReset;
      cfg_q.stall_ticks          <= esr_pkg::StallTicksReset;
      cfg_q.start_speed_straight <= esr_pkg::StartStrReset;
      cfg_q.max_speed_straight   <= esr_pkg::MaxStrReset;
      cfg_q.start_speed_turn     <= esr_pkg::StartTurnReset;
      cfg_q.max_speed_turn       <= esr_pkg::MaxTurnReset;
    end else if (wr_en) begin
      case (reg_idx)
        esr_pkg::REG_ENC_MIDDLE:  cfg_q.encoder_middle       <= pwdata[9:0];
        esr_pkg::REG_SLOW_INTV:   cfg_q.slow_interval        <= pwdata[10:0];
        esr_pkg::REG_FAST_INTV:   cfg_q.fast_interval        <= pwdata[10:0];
        esr_pkg::REG_STALL_TICKS: cfg_q.stall_ticks          <= pwdata[9:0];
        esr_pkg::REG_START_STR:   cfg_q.start_speed_straight <= pwdata[7:0];
        esr_pkg::REG_MAX_STR:     cfg_q.max_speed_straight   <= pwdata[7:0];
        esr_pkg::REG_START_TURN:  cfg_q.start_speed_turn     <= pwdata[7:0];
        esr_pkg::REG_MAX_TURN:    cfg_q.max_speed_turn       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      esr_pkg::REG_ENC_MIDDLE:  prdata = {22'd0, cfg_q.encoder_middle};
      esr_pkg::REG_SLOW_INTV:   prdata = {21'd0, cfg_q.slow_interval};
      esr_pkg::REG_FAST_INTV:   prdata = {21'd0, cfg_q.fast_interval};
      esr_pkg::REG_STALL_TICKS: prdata = {22'd0, cfg_q.stall_ticks};
      esr_pkg::REG_START_STR:   prdata = {24'd0, cfg_q.start_speed_straight};
      esr_pkg::REG_MAX_STR:     prdata = {24'd0, cfg_q.max_speed_straight};
      esr_pkg::REG_START_TURN:  prdata = {24'd0, cfg_q.start_speed_turn};
      esr_pkg::REG_MAX_TURN:    prdata = {24'd0, cfg_q.max_speed_turn};
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: rtl/esr_core.sv
// Regulator state and the per-tick update: classing, sector detection, stall detection,
// interval scaling, median and speed step. Depends on esr_pkg.
module esr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [2:0]    mode_i,
  input  logic [9:0]    encoder_sample_i,
  input  esr_pkg::cfg_t cfg_i,
  output esr_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_GATHER = 2'd2,
    PH_REG    = 2'd3
  } phase_e;

  phase_e          phase_q, phase_d;
  esr_pkg::act_e   action_q, action_d;
  esr_pkg::cls_e   last_q, last_d;
  logic [9:0]      ticks_q, ticks_d;
  logic [10:0]     store_q [3];
  logic [10:0]     store_d [3];
  logic [1:0]      ptr_q, ptr_d;
  logic [1:0]      gathered_q, gathered_d;
  logic [7:0]      speed_q, speed_d;
  logic [7:0]      ceil_q, ceil_d;
  logic [3:0]      holdoff_q, holdoff_d;
  logic [15:0]     sectors_q, sectors_d;
  logic            fault_q, fault_d;

  esr_pkg::act_e   act_in;
  esr_pkg::cls_e   cls_now;
  logic [10:0]     low_lim, high_lim;
  logic [9:0]      ticks_inc;
  logic [12:0]     ticks_x5;
  logic [23:0]     third_prod;
  logic [10:0]     iv;
  logic [10:0]     med;
  logic [1:0]      wr_sel;
  logic            turn;
  logic            do_eval;
  logic            sector_ev;

  function automatic logic [10:0] median3(logic [10:0] a, logic [10:0] b, logic [10:0] c);
    logic [10:0] lo;
    logic [10:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  assign act_in = (mode_i > esr_pkg::ACT_RIGHT) ? esr_pkg::ACT_STOP : esr_pkg::act_e'(mode_i);

  // sample <= middle - margin and sample >= middle + margin, kept unsigned.
  assign low_lim  = {1'b0, encoder_sample_i} + esr_pkg::ClassMargin;
  assign high_lim = {1'b0, cfg_i.encoder_middle} + esr_pkg::ClassMargin;

  always_comb begin
    if (low_lim <= {1'b0, cfg_i.encoder_middle}) begin
      cls_now = esr_pkg::CL_LOW;
    end else if ({1'b0, encoder_sample_i} >= high_lim) begin
      cls_now = esr_pkg::CL_HIGH;
    end else begin
      cls_now = esr_pkg::CL_UNSURE;
    end
  end

  assign ticks_inc = (ticks_q != 10'h3FF) ? ticks_q + 10'd1 : ticks_q;

  // 5/4 is a shift; 5/6 is (5t/2)/3 done as a multiply by 2731/8192, exact below 8192.
  assign ticks_x5   = {3'd0, ticks_inc} + {1'b0, ticks_inc, 2'b00};
  assign third_prod = {12'd0, ticks_x5[12:1]} * 24'd2731;
  assign iv = (cls_now == esr_pkg::CL_HIGH) ? ticks_x5[12:2] : third_prod[23:13];

  always_comb begin
    phase_d    = phase_q;
    action_d   = action_q;
    last_d     = last_q;
    ticks_d    = ticks_q;
    store_d    = store_q;
    ptr_d      = ptr_q;
    gathered_d = gathered_q;
    speed_d    = speed_q;
    ceil_d     = ceil_q;
    holdoff_d  = holdoff_q;
    sectors_d  = sectors_q;
    fault_d    = fault_q;
    turn       = (act_in == esr_pkg::ACT_LEFT) || (act_in == esr_pkg::ACT_RIGHT);
    wr_sel     = (ptr_q > 2'd2) ? 2'd0 : ptr_q;
    do_eval    = 1'b0;
    sector_ev  = 1'b0;

    if (!fault_q) begin
      if (act_in != action_q) begin
        action_d = act_in;
        phase_d  = PH_IDLE;
        if (act_in != esr_pkg::ACT_STOP) begin
          speed_d    = turn ? cfg_i.start_speed_turn : cfg_i.start_speed_straight;
          ceil_d     = turn ? cfg_i.max_speed_turn : cfg_i.max_speed_straight;
          sectors_d  = '0;
          last_d     = cls_now;
          ticks_d    = '0;
          gathered_d = '0;
          ptr_d      = '0;
          holdoff_d  = '0;
          phase_d    = PH_FIRST;
        end
      end else if (phase_q != PH_IDLE) begin
        ticks_d = ticks_inc;
        if ((cls_now != esr_pkg::CL_UNSURE) && (cls_now != last_q)) begin
          sector_ev = 1'b1;
          sectors_d = sectors_q + 16'd1;
          last_d    = cls_now;
          ticks_d   = '0;
          case (phase_q)
            PH_FIRST: begin
              phase_d    = PH_GATHER;
              gathered_d = '0;
            end
            PH_GATHER: begin
              if (gathered_q != 2'd3) begin
                store_d[gathered_q] = iv;
              end
              if (gathered_q >= 2'd2) begin
                gathered_d = 2'd3;
                phase_d    = PH_REG;
                ptr_d      = '0;
                holdoff_d  = esr_pkg::InitialHoldoff;
                do_eval    = 1'b1;
              end else begin
                gathered_d = gathered_q + 2'd1;
              end
            end
            default: begin
              store_d[wr_sel] = iv;
              ptr_d = (wr_sel == 2'd2) ? 2'd0 : wr_sel + 2'd1;
              if (holdoff_q != 4'd0) begin
                holdoff_d = holdoff_q - 4'd1;
              end
              do_eval = 1'b1;
            end
          endcase
        end else if (ticks_inc >= cfg_i.stall_ticks) begin
          fault_d  = 1'b1;
          phase_d  = PH_IDLE;
          action_d = esr_pkg::ACT_STOP;
        end
      end
    end

    // Speed step from the median of the freshly updated interval store.
    med = median3(store_d[0], store_d[1], store_d[2]);
    if (do_eval && (holdoff_d == 4'd0)) begin
      if (med > cfg_i.slow_interval) begin
        if (speed_d < ceil_d) begin
          speed_d   = speed_d + 8'd1;
          holdoff_d = esr_pkg::AdjustHoldoff;
        end
      end else if (med < cfg_i.fast_interval) begin
        if (speed_d != 8'd0) begin
          speed_d   = speed_d - 8'd1;
          holdoff_d = esr_pkg::AdjustHoldoff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      action_q   <= esr_pkg::ACT_STOP;
      last_q     <= esr_pkg::CL_UNSURE;
      ticks_q    <= '0;
      store_q    <= '{default: '0};
      ptr_q      <= '0;
      gathered_q <= '0;
      speed_q    <= '0;
      ceil_q     <= '0;
      holdoff_q  <= '0;
      sectors_q  <= '0;
      fault_q    <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      action_q   <= action_d;
      last_q     <= last_d;
      ticks_q    <= ticks_d;
      store_q    <= store_d;
      ptr_q      <= ptr_d;
      gathered_q <= gathered_d;
      speed_q    <= speed_d;
      ceil_q     <= ceil_d;
      holdoff_q  <= holdoff_d;
      sectors_q  <= sectors_d;
      fault_q    <= fault_d;
    end
  end

  assign res_o.motor_enable  = (phase_d != PH_IDLE) && !fault_d;
  assign res_o.motor_reverse = (action_d == esr_pkg::ACT_BACK) ||
                               (action_d == esr_pkg::ACT_LEFT);
  assign res_o.drive_level   = speed_d;
  assign res_o.sector_count  = sectors_d;
  assign res_o.sector_event  = sector_ev;
  assign res_o.stall_fault   = fault_d;

endmodule

// File: rtl/encoder_speed_regulator.sv
// Top level of the encoder speed regulator: input register, regulator core, result register.
// Depends on esr_pkg, esr_cfg_regs and esr_core.
//
//   channel   direction  handshake              payload
//   in        to block   in_valid_i/in_ready_o  mode_i, encoder_sample_i
//   out       from block out_valid_o/out_ready_i motor_enable_o .. stall_fault_o
//   config    to block   psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One request is taken every cycle while the result is not stalled; its result is offered once it has
// passed the input register and the result register. The regulator state updates from the input register.
// Reset clears all regulator state and loads the register defaults.
// A stalled result holds the result register; the input register still takes one more request.
module encoder_speed_regulator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           mode_i,
  input  logic [9:0]                           encoder_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 motor_enable_o,
  output logic                                 motor_reverse_o,
  output logic [7:0]                           drive_level_o,
  output logic [15:0]                          sector_count_o,
  output logic                                 sector_event_o,
  output logic                                 stall_fault_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [esr_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [esr_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [esr_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                 pready
);

  esr_pkg::cfg_t cfg;
  esr_pkg::res_t res;
  esr_pkg::res_t res_q;
  logic          in_valid_q;
  logic [2:0]    mode_q;
  logic [9:0]    sample_q;
  logic          out_valid_q;
  logic          advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  esr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esr_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .mode_i           (mode_q),
    .encoder_sample_i (sample_q),
    .cfg_i            (cfg),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      sample_q <= encoder_sample_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_enable_o  = res_q.motor_enable;
  assign motor_reverse_o = res_q.motor_reverse;
  assign drive_level_o   = res_q.drive_level;
  assign sector_count_o  = res_q.sector_count;
  assign sector_event_o  = res_q.sector_event;
  assign stall_fault_o   = res_q.stall_fault;

endmodule
